// ===== sv/assert_macros.svh =====
// Assertion macros shared by the message parser RTL.
// Depends on nothing; each user supplies its clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds on a rising clock edge outside of reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== sv/coapmp_pkg.sv =====
// Shared types and codes for the CoAP message parser.
// Used by coapmp_core and coap_message_parser_unit; depends on nothing.
package coapmp_pkg;

   // Role of each byte of the datagram
   localparam logic [2:0] KIND_HEADER  = 3'd0;
   localparam logic [2:0] KIND_TOKEN   = 3'd1;
   localparam logic [2:0] KIND_OPT_HD  = 3'd2;
   localparam logic [2:0] KIND_OPT_EXT = 3'd3;
   localparam logic [2:0] KIND_VALUE   = 3'd4;
   localparam logic [2:0] KIND_MARKER  = 3'd5;
   localparam logic [2:0] KIND_PAYLOAD = 3'd6;
   localparam logic [2:0] KIND_IGNORED = 3'd7;

   // Status codes, first error of the datagram wins
   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_SHORT     = 3'd1;
   localparam logic [2:0] STAT_VERSION   = 3'd2;
   localparam logic [2:0] STAT_TOKEN_LEN = 3'd3;
   localparam logic [2:0] STAT_NIBBLE    = 3'd4;
   localparam logic [2:0] STAT_TRUNC     = 3'd5;
   localparam logic [2:0] STAT_OVERFLOW  = 3'd6;

   // Protocol constants
   localparam logic [7:0]  PAYLOAD_MARKER = 8'hFF;
   localparam logic [1:0]  COAP_VERSION   = 2'd1;
   localparam logic [3:0]  MAX_TOKEN_LEN  = 4'd8;
   localparam logic [3:0]  NIB_EXT8       = 4'd13;
   localparam logic [3:0]  NIB_EXT16      = 4'd14;
   localparam logic [3:0]  NIB_RESERVED   = 4'd15;
   localparam logic [16:0] EXT8_BIAS      = 17'd13;
   localparam logic [16:0] EXT16_BIAS     = 17'd269;
   localparam logic [15:0] URI_PATH_OPT   = 16'd11;

   // One result per request byte
   typedef struct packed {
      logic [2:0]  item_kind;
      logic [7:0]  data_out;
      logic [15:0] option_number;
      logic        value_first;
      logic        is_uri_path;
      logic [1:0]  msg_type;
      logic [3:0]  token_length;
      logic [7:0]  method_code;
      logic [15:0] message_id;
      logic        message_done;
      logic [2:0]  status;
   } result_type;

endpackage

// ===== sv/coapmp_core.sv =====
// Byte-level decoder for the CoAP message parser: parse state and result logic.
// Depends on coapmp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module coapmp_core
   import coapmp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,        // request accepted this cycle
   input  logic [7:0] data_byte,
   input  logic       last_byte,
   output result_type result      // result for the byte at the input
);

   typedef enum logic [2:0] {
      PH_HEADER, PH_TOKEN, PH_OPT_HEAD, PH_DLT_EXT,
      PH_LEN_EXT, PH_VALUE, PH_PAYLOAD, PH_ERROR
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [1:0]  hdr_count;
      logic [1:0]  msg_type;
      logic [3:0]  token_len;
      logic [7:0]  code;
      logic [15:0] msg_id;
      logic [3:0]  token_left;
      logic [15:0] run_opt;
      logic [3:0]  len_nib;
      logic [7:0]  ext_acc;
      logic [1:0]  ext_left;
      logic        ext_wide;
      logic [16:0] value_left;
      logic        first_pending;
      logic [2:0]  err;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase: PH_HEADER, hdr_count: 2'd0, msg_type: 2'd0, token_len: 4'd0,
      code: 8'd0, msg_id: 16'd0, token_left: 4'd0, run_opt: 16'd0,
      len_nib: 4'd0, ext_acc: 8'd0, ext_left: 2'd0, ext_wide: 1'b0,
      value_left: 17'd0, first_pending: 1'b0, err: STAT_OK};

   state_type   state_ff, state_in;
   logic        ext_done;
   logic [16:0] ext_val;
   logic [16:0] delta_val;
   logic [17:0] opt_sum;
   logic        opt_over;
   logic        do_delta, do_length;
   logic [16:0] length_val;
   logic [2:0]  kind;
   logic        vfirst, uri;

   // Extension byte value and running option sum
   assign ext_done  = !(state_ff.ext_wide && (state_ff.ext_left == 2'd2));
   assign ext_val   = state_ff.ext_wide ? (EXT16_BIAS + {1'b0, state_ff.ext_acc, data_byte})
                                        : (EXT8_BIAS + {9'd0, data_byte});
   assign delta_val = (state_ff.phase == PH_OPT_HEAD) ? {13'd0, data_byte[7:4]} : ext_val;
   assign opt_sum   = {2'b00, state_ff.run_opt} + {1'b0, delta_val};
   assign opt_over  = (opt_sum[17:16] != 2'b00);

   // Decode one byte
   always_comb begin
      state_in   = state_ff;
      kind       = KIND_IGNORED;
      vfirst     = 1'b0;
      uri        = 1'b0;
      do_delta   = 1'b0;
      do_length  = 1'b0;
      length_val = {13'd0, state_ff.len_nib};

      unique case (state_ff.phase)
         PH_HEADER: begin
            kind = KIND_HEADER;
            unique case (state_ff.hdr_count)
               2'd0: begin
                  state_in.msg_type  = data_byte[5:4];
                  state_in.token_len = data_byte[3:0];
                  state_in.code      = 8'd0;
                  state_in.msg_id    = 16'd0;
                  state_in.hdr_count = 2'd1;
                  if (data_byte[7:6] != COAP_VERSION) begin
                     state_in.err   = STAT_VERSION;
                     state_in.phase = PH_ERROR;
                  end else if (data_byte[3:0] > MAX_TOKEN_LEN) begin
                     state_in.err   = STAT_TOKEN_LEN;
                     state_in.phase = PH_ERROR;
                  end
               end
               2'd1: begin
                  state_in.code      = data_byte;
                  state_in.hdr_count = 2'd2;
               end
               2'd2: begin
                  state_in.msg_id    = {8'd0, data_byte};
                  state_in.hdr_count = 2'd3;
               end
               default: begin
                  state_in.msg_id     = {state_ff.msg_id[7:0], data_byte};
                  state_in.hdr_count  = 2'd0;
                  state_in.token_left = state_ff.token_len;
                  state_in.phase      = (state_ff.token_len != 4'd0) ? PH_TOKEN
                                                                    : PH_OPT_HEAD;
               end
            endcase
         end
         PH_TOKEN: begin
            kind = KIND_TOKEN;
            state_in.token_left = state_ff.token_left - 4'd1;
            if (state_in.token_left == 4'd0) state_in.phase = PH_OPT_HEAD;
         end
         PH_OPT_HEAD: begin
            if (data_byte == PAYLOAD_MARKER) begin
               kind           = KIND_MARKER;
               state_in.phase = PH_PAYLOAD;
            end else begin
               kind = KIND_OPT_HD;
               if (data_byte[7:4] == NIB_RESERVED || data_byte[3:0] == NIB_RESERVED) begin
                  state_in.err   = STAT_NIBBLE;
                  state_in.phase = PH_ERROR;
               end else begin
                  state_in.len_nib = data_byte[3:0];
                  if (data_byte[7:4] < NIB_EXT8) begin
                     do_delta = 1'b1;
                  end else begin
                     state_in.phase    = PH_DLT_EXT;
                     state_in.ext_wide = (data_byte[7:4] == NIB_EXT16);
                     state_in.ext_left = (data_byte[7:4] == NIB_EXT16) ? 2'd2 : 2'd1;
                     state_in.ext_acc  = 8'd0;
                  end
               end
            end
         end
         PH_DLT_EXT, PH_LEN_EXT: begin
            kind = KIND_OPT_EXT;
            if (!ext_done) begin
               state_in.ext_acc  = data_byte;
               state_in.ext_left = 2'd1;
            end else begin
               state_in.ext_left = 2'd0;
               if (state_ff.ext_wide) state_in.ext_acc = data_byte;
               if (state_ff.phase == PH_DLT_EXT) begin
                  do_delta = 1'b1;
               end else begin
                  do_length  = 1'b1;
                  length_val = ext_val;
               end
            end
         end
         PH_VALUE: begin
            kind   = KIND_VALUE;
            uri    = (state_ff.run_opt == URI_PATH_OPT);
            vfirst = state_ff.first_pending;
            state_in.first_pending = 1'b0;
            state_in.value_left    = state_ff.value_left - 17'd1;
            if (state_in.value_left == 17'd0) state_in.phase = PH_OPT_HEAD;
         end
         PH_PAYLOAD: kind = KIND_PAYLOAD;
         default:    kind = KIND_IGNORED;
      endcase

      // Add the delta, then take the length from the nibble or its extension
      if (do_delta) begin
         if (opt_over) begin
            state_in.err   = STAT_OVERFLOW;
            state_in.phase = PH_ERROR;
         end else begin
            state_in.run_opt = opt_sum[15:0];
            if (state_in.len_nib < NIB_EXT8) begin
               do_length  = 1'b1;
               length_val = {13'd0, state_in.len_nib};
            end else begin
               state_in.phase    = PH_LEN_EXT;
               state_in.ext_wide = (state_in.len_nib == NIB_EXT16);
               state_in.ext_left = (state_in.len_nib == NIB_EXT16) ? 2'd2 : 2'd1;
               state_in.ext_acc  = 8'd0;
            end
         end
      end
      if (do_length) begin
         state_in.value_left    = length_val;
         state_in.first_pending = 1'b1;
         state_in.phase         = (length_val != 17'd0) ? PH_VALUE : PH_OPT_HEAD;
      end

      // Flag a datagram that ends early
      if (last_byte && state_in.err == STAT_OK) begin
         if (state_in.phase == PH_HEADER || state_in.phase == PH_TOKEN)
            state_in.err = STAT_SHORT;
         else if (state_in.phase == PH_DLT_EXT || state_in.phase == PH_LEN_EXT ||
                  state_in.phase == PH_VALUE)
            state_in.err = STAT_TRUNC;
      end
   end

   // Assemble the result
   always_comb begin
      result.item_kind     = kind;
      result.data_out      = data_byte;
      result.option_number = (kind == KIND_OPT_HD || kind == KIND_OPT_EXT ||
                              kind == KIND_VALUE) ? state_in.run_opt : 16'd0;
      result.value_first   = vfirst;
      result.is_uri_path   = uri;
      result.msg_type      = state_in.msg_type;
      result.token_length  = state_in.token_len;
      result.method_code   = state_in.code;
      result.message_id    = state_in.msg_id;
      result.message_done  = last_byte;
      result.status        = state_in.err;
   end

   // Advance on each request, back to reset after the final byte
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (step) begin
         state_ff <= last_byte ? STATE_RESET : state_in;
      end
   end

   `ASSERT_CLK(a_last_clears, clock, reset,
      step && last_byte |=> state_ff.phase == PH_HEADER && state_ff.err == STAT_OK,
      "state not cleared after final byte")
   `ASSERT_CLK(a_err_sticks, clock, reset,
      state_ff.phase == PH_ERROR |-> state_ff.err != STAT_OK,
      "error phase without error code")
endmodule

// ===== sv/coap_message_parser_unit.sv =====
// CoAP message parser, top level: stream ports and result register.
// Depends on coapmp_pkg, coapmp_core and assert_macros.svh.
//
// Takes one datagram byte per request and returns one result per byte, in the
// cycle after the byte is accepted. A new byte is taken every cycle while the
// result side keeps up: the only storage between the two sides is the result
// register, which loads a new result in the same cycle that the old one is
// taken. Each byte's header, token and option decode is done in one pass
// through the decoder between the parse state and that register.
`include "assert_macros.svh"

module coap_message_parser_unit
   import coapmp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [7:0] data_out, [23:8] option_number,
                                    // [24] value_first, [25] is_uri_path,
                                    // [27:26] msg_type, [31:28] token_length,
                                    // [39:32] method_code, [55:40] message_id,
                                    // [58:56] status, [63:59] zero
   output logic [2:0]  rsp_tuser,   // [2:0] item_kind
   output logic        rsp_tlast    // message_done
);

   logic       rsp_valid_ff;
   result_type rsp_data_ff;
   result_type core_result;
   logic       accept;

   // Take a request whenever the result register is free or being drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   coapmp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (accept),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .result    (core_result)
   );

   // Hold the result until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= core_result;
      end
   end

   // Pack the result onto the stream
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.item_kind;
   assign rsp_tlast  = rsp_data_ff.message_done;
   assign rsp_tdata  = {5'd0, rsp_data_ff.status, rsp_data_ff.message_id,
                        rsp_data_ff.method_code, rsp_data_ff.token_length,
                        rsp_data_ff.msg_type, rsp_data_ff.is_uri_path,
                        rsp_data_ff.value_first, rsp_data_ff.option_number,
                        rsp_data_ff.data_out};

   `ASSERT_CLK(a_first_is_value, clock, reset,
      rsp_tvalid && rsp_data_ff.value_first |-> rsp_tuser == KIND_VALUE,
      "value_first on a non-value byte")
   `ASSERT_CLK(a_ignored_has_err, clock, reset,
      rsp_tvalid && rsp_tuser == KIND_IGNORED |-> rsp_data_ff.status != STAT_OK,
      "ignored byte without error status")
   `ASSERT_NEVER(a_uri_number, clock, reset,
      rsp_tvalid && rsp_data_ff.is_uri_path && rsp_data_ff.option_number != URI_PATH_OPT,
      "URI-Path flag on wrong option")
endmodule

// ===== sim/tb_coap_message_parser_unit.sv =====
// Testbench for coap_message_parser_unit: stream requests in, one checked result per byte.
// Depends on coapmp_pkg and the parser RTL; holds its own byte-level parse predictor.
`timescale 1ns / 100ps

module tb_coap_message_parser_unit;
   import coapmp_pkg::*;

   // Parse phases of the predictor
   typedef enum logic [2:0] {
      PH_HDR, PH_TOK, PH_HEAD, PH_DEXT, PH_LEXT, PH_VAL, PH_PAY, PH_ERR
   } parse_phase_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   coap_message_parser_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Predictor state
   parse_phase_type ph;
   logic [1:0]   hdr_cnt;
   logic [1:0]   p_type;
   logic [3:0]   p_tkl;
   logic [7:0]   p_code;
   logic [15:0]  p_mid;
   logic [3:0]   tok_left;
   logic [16:0]  opt_num;
   logic [3:0]   len_nib;
   logic [15:0]  ext_acc;
   logic [16:0]  val_left;
   logic [2:0]   err;
   logic [1:0]   ext_left;
   logic         ext_wide;
   logic         first_pend;
   int unsigned  ext_value;

   result_type   expected_results[$];
   logic [7:0]   msg_bytes[$];

   int unsigned  send_idle_pct = 24;
   int unsigned  recv_idle_pct = 78;
   int unsigned  wide_len_budget = 1;
   int unsigned  requests_sent = 0;
   int unsigned  datagrams_sent = 0;
   int unsigned  parsed_requests = 0;
   int unsigned  results_checked = 0;
   int unsigned  fail_count = 0;
   int unsigned  status_hits[0:7];

   function automatic void clear_parse();
      ph = PH_HDR;
      hdr_cnt = '0;
      p_type = '0;
      p_tkl = '0;
      p_code = '0;
      p_mid = '0;
      tok_left = '0;
      opt_num = '0;
      len_nib = '0;
      ext_acc = '0;
      val_left = '0;
      err = STAT_OK;
      ext_left = '0;
      ext_wide = 1'b0;
      first_pend = 1'b0;
   endfunction

   // Keep the first error, stop decoding
   function automatic void raise_err(input logic [2:0] code);
      if (err == STAT_OK) err = code;
      ph = PH_ERR;
   endfunction

   function automatic void begin_ext(input logic [3:0] nib);
      ext_wide = (nib == NIB_EXT16);
      ext_left = ext_wide ? 2'd2 : 2'd1;
      ext_acc = '0;
   endfunction

   // Take one extension byte; return 1 with ext_value set once decoded
   function automatic bit take_ext(input logic [7:0] b);
      if (ext_wide && ext_left == 2'd2) begin
         ext_acc = {8'h00, b};
         ext_left = 2'd1;
         return 1'b0;
      end
      ext_left = 2'd0;
      if (ext_wide) begin
         ext_acc = {ext_acc[7:0], b};
         ext_value = int'(EXT16_BIAS) + ext_acc;
      end else begin
         ext_value = int'(EXT8_BIAS) + b;
      end
      return 1'b1;
   endfunction

   function automatic void load_length(input int unsigned len);
      val_left = len[16:0];
      first_pend = 1'b1;
      ph = (val_left != 0) ? PH_VAL : PH_HEAD;
   endfunction

   function automatic void add_delta(input int unsigned d);
      int unsigned sum;
      sum = opt_num + d;
      if (sum > 32'd65535) begin
         raise_err(STAT_OVERFLOW);
      end else begin
         opt_num = sum[16:0];
         if (len_nib < NIB_EXT8) begin
            load_length(32'(len_nib));
         end else begin
            ph = PH_LEXT;
            begin_ext(len_nib);
         end
      end
   endfunction

   // Advance the parse by one request byte and build its result
   function automatic result_type predict_result(input logic [7:0] b, input logic lst);
      result_type r;
      logic [3:0] dn;
      logic [3:0] ln;
      r = '0;
      r.item_kind = KIND_IGNORED;
      r.data_out = b;
      case (ph)
         PH_HDR: begin
            r.item_kind = KIND_HEADER;
            case (hdr_cnt)
               2'd0: begin
                  p_type = b[5:4];
                  p_tkl = b[3:0];
                  p_code = '0;
                  p_mid = '0;
                  hdr_cnt = 2'd1;
                  if (b[7:6] != COAP_VERSION) raise_err(STAT_VERSION);
                  else if (p_tkl > MAX_TOKEN_LEN) raise_err(STAT_TOKEN_LEN);
               end
               2'd1: begin
                  p_code = b;
                  hdr_cnt = 2'd2;
               end
               2'd2: begin
                  p_mid = {8'h00, b};
                  hdr_cnt = 2'd3;
               end
               default: begin
                  p_mid = {p_mid[7:0], b};
                  hdr_cnt = 2'd0;
                  tok_left = p_tkl;
                  ph = (tok_left != 0) ? PH_TOK : PH_HEAD;
               end
            endcase
         end
         PH_TOK: begin
            r.item_kind = KIND_TOKEN;
            if (tok_left != 0) tok_left = tok_left - 4'd1;
            if (tok_left == 0) ph = PH_HEAD;
         end
         PH_HEAD: begin
            if (b == PAYLOAD_MARKER) begin
               r.item_kind = KIND_MARKER;
               ph = PH_PAY;
            end else begin
               r.item_kind = KIND_OPT_HD;
               dn = b[7:4];
               ln = b[3:0];
               if (dn == NIB_RESERVED || ln == NIB_RESERVED) begin
                  raise_err(STAT_NIBBLE);
               end else begin
                  len_nib = ln;
                  if (dn < NIB_EXT8) begin
                     add_delta(32'(dn));
                  end else begin
                     ph = PH_DEXT;
                     begin_ext(dn);
                  end
               end
               r.option_number = opt_num[15:0];
            end
         end
         PH_DEXT: begin
            r.item_kind = KIND_OPT_EXT;
            if (take_ext(b)) add_delta(ext_value);
            r.option_number = opt_num[15:0];
         end
         PH_LEXT: begin
            r.item_kind = KIND_OPT_EXT;
            if (take_ext(b)) load_length(ext_value);
            r.option_number = opt_num[15:0];
         end
         PH_VAL: begin
            r.item_kind = KIND_VALUE;
            r.option_number = opt_num[15:0];
            r.is_uri_path = (opt_num == {1'b0, URI_PATH_OPT});
            r.value_first = first_pend;
            first_pend = 1'b0;
            if (val_left != 0) val_left = val_left - 17'd1;
            if (val_left == 0) ph = PH_HEAD;
         end
         PH_PAY: begin
            r.item_kind = KIND_PAYLOAD;
         end
         default: begin
            r.item_kind = KIND_IGNORED;
         end
      endcase

      // Ending early sets a status unless an error came first
      if (lst && err == STAT_OK) begin
         if (ph == PH_HDR || ph == PH_TOK) err = STAT_SHORT;
         else if (ph == PH_DEXT || ph == PH_LEXT || ph == PH_VAL) err = STAT_TRUNC;
      end

      r.msg_type = p_type;
      r.token_length = p_tkl;
      r.method_code = p_code;
      r.message_id = p_mid;
      r.message_done = lst;
      r.status = err;
      if (lst) clear_parse();
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      fail_count++;
      $display("%0t: result %0d: %s expected %0h got %0h",
               $realtime, results_checked, what, want, got);
   endtask

   task automatic check_field(input string what, input int unsigned want,
                              input int unsigned got);
      if (want != got) report_mismatch(what, want, got);
   endtask

   // Receiver: drop tready at random per the current idle rate
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
   end

   // Check each accepted result, then predict for each accepted request
   always @(posedge clock) begin
      result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result, data_out", 0, rsp_tdata[7:0]);
            end else begin
               want = expected_results.pop_front();
               check_field("item_kind", want.item_kind, rsp_tuser);
               check_field("data_out", want.data_out, rsp_tdata[7:0]);
               check_field("option_number", want.option_number, rsp_tdata[23:8]);
               check_field("value_first", want.value_first, rsp_tdata[24]);
               check_field("is_uri_path", want.is_uri_path, rsp_tdata[25]);
               check_field("msg_type", want.msg_type, rsp_tdata[27:26]);
               check_field("token_length", want.token_length, rsp_tdata[31:28]);
               check_field("method_code", want.method_code, rsp_tdata[39:32]);
               check_field("message_id", want.message_id, rsp_tdata[55:40]);
               check_field("status", want.status, rsp_tdata[58:56]);
               check_field("message_done", want.message_done, rsp_tlast);
               if (want.message_done) status_hits[want.status]++;
            end
            results_checked++;
         end
         if (req_tvalid && req_tready) begin
            want = predict_result(req_tdata, req_tlast);
            if (want.item_kind != KIND_IGNORED) parsed_requests++;
            expected_results.push_back(want);
         end
      end
   end

   // Send one request byte; enter and leave at a falling edge
   task automatic send_byte(input logic [7:0] b, input logic lst);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= lst;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic send_message();
      int unsigned i;
      for (i = 0; i < msg_bytes.size(); i++)
         send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
      datagrams_sent++;
   endtask

   function automatic logic [3:0] ext_nibble(input int unsigned v);
      if (v < 13) return v[3:0];
      else if (v < 269) return NIB_EXT8;
      else return NIB_EXT16;
   endfunction

   task automatic push_extension(input int unsigned v);
      int unsigned w;
      if (v >= 269) begin
         w = v - 269;
         msg_bytes.push_back(w[15:8]);
         msg_bytes.push_back(w[7:0]);
      end else if (v >= 13) begin
         w = v - 13;
         msg_bytes.push_back(w[7:0]);
      end
   endtask

   // Build a mostly well-formed datagram with random content, sometimes broken
   task automatic compose_message();
      int unsigned n_opt, run, dv, lv, pick, i, j, cnt, cut;
      logic [3:0]  tkl, dn, ln;
      msg_bytes.delete();
      tkl = 4'($urandom_range(8, 0));
      if ($urandom_range(99, 0) < 8) msg_bytes.push_back(8'($urandom));
      else msg_bytes.push_back({COAP_VERSION, 2'($urandom), tkl});
      for (i = 0; i < 3; i++) msg_bytes.push_back(8'($urandom));
      for (i = 0; i < tkl; i++) msg_bytes.push_back(8'($urandom));

      // options, often steering toward URI-Path
      n_opt = $urandom_range(4, 0);
      run = 0;
      for (i = 0; i < n_opt; i++) begin
         pick = $urandom_range(99, 0);
         if (pick < 30 && run <= 11) dv = 11 - run;
         else if (pick < 65) dv = $urandom_range(12, 0);
         else if (pick < 85) dv = $urandom_range(268, 13);
         else if (pick < 95) dv = $urandom_range(800, 269);
         else dv = 269 + $urandom_range(65535, 0);
         pick = $urandom_range(99, 0);
         if (pick < 70) begin
            lv = $urandom_range(12, 0);
         end else if (pick < 97 || wide_len_budget == 0) begin
            lv = $urandom_range(24, 13);
         end else begin
            lv = $urandom_range(272, 269);
            wide_len_budget--;
         end
         run += dv;
         dn = ext_nibble(dv);
         ln = ext_nibble(lv);
         pick = $urandom_range(99, 0);
         if (pick < 2) dn = NIB_RESERVED;
         else if (pick < 4) ln = NIB_RESERVED;
         msg_bytes.push_back({dn, ln});
         push_extension(dv);
         push_extension(lv);
         for (j = 0; j < lv; j++) msg_bytes.push_back(8'($urandom));
      end

      if ($urandom_range(1, 0) == 1) begin
         msg_bytes.push_back(PAYLOAD_MARKER);
         cnt = $urandom_range(10, 0);
         for (j = 0; j < cnt; j++) msg_bytes.push_back(8'($urandom));
      end

      // cut short or corrupt a byte now and then
      if ($urandom_range(99, 0) < 15 && msg_bytes.size() > 1) begin
         cut = $urandom_range(msg_bytes.size() - 1, 1);
         while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
      end
      if ($urandom_range(99, 0) < 6)
         msg_bytes[$urandom_range(msg_bytes.size() - 1, 0)] = 8'($urandom);
   endtask

   // Bad version, long token, message ending in the header
   task automatic test_header_cases();
      msg_bytes = '{8'hC0};
      send_message();
      msg_bytes = '{8'h49, 8'h00};
      send_message();
      msg_bytes = '{8'h40};
      send_message();
   endtask

   // Marker as last byte, reserved nibble, option overflow, truncated URI-Path value
   task automatic test_option_cases();
      msg_bytes = '{8'h50, 8'h01, 8'h00, 8'h01, 8'hFF};
      send_message();
      msg_bytes = '{8'h40, 8'h02, 8'h00, 8'h02, 8'h1F};
      send_message();
      msg_bytes = '{8'h40, 8'hFF, 8'hFF, 8'hFF, 8'hE0, 8'hFF, 8'hFF};
      send_message();
      msg_bytes = '{8'h40, 8'h01, 8'h00, 8'h03, 8'hB2, 8'h61};
      send_message();
   endtask

   task automatic test_random_messages(input int unsigned send_pct,
                                       input int unsigned recv_pct,
                                       input int unsigned n_items);
      int unsigned start;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      start = requests_sent;
      while (requests_sent - start < n_items) begin
         compose_message();
         send_message();
      end
   endtask

   initial begin
      int i;
      for (i = 0; i < 8; i++) status_hits[i] = 0;
      clear_parse();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_header_cases();
      test_option_cases();
      test_random_messages(24, 78, 208);
      test_random_messages(78, 24, 208);
      test_random_messages(0, 0, 207);
      req_tvalid <= 1'b0;

      // drain outstanding results, then allow the register stage to settle
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d requests (%0d decoded) in %0d datagrams; %0d results compared.",
               requests_sent, parsed_requests, datagrams_sent, results_checked);
      $display("End status: ok %0d, short %0d, version %0d, token %0d, nibble %0d,",
               status_hits[STAT_OK], status_hits[STAT_SHORT], status_hits[STAT_VERSION],
               status_hits[STAT_TOKEN_LEN], status_hits[STAT_NIBBLE],
               " trunc %0d, overflow %0d",
               status_hits[STAT_TRUNC], status_hits[STAT_OVERFLOW]);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("timeout with %0d results still outstanding", expected_results.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
